[src/glb_pkg.sv]
// Package for the greedy line breaker: field widths, register indexes, reset values,
// configuration, controller state and the command/status structs.
// No dependencies; every other file of the block imports it.
package glb_pkg;

    localparam int W_LEN   = 8;
    localparam int W_FILL  = 9;
    localparam int W_IDX   = 16;
    localparam int W_LINES = 17;
    localparam int W_COST  = 31;
    localparam int W_BASE  = 16;
    localparam int W_PROD  = W_COST + W_BASE;
    localparam int W_EXP   = 3;
    localparam int W_WT    = 8;
    localparam int W_MAXL  = 16;
    localparam int W_ADDR  = 4;
    localparam int W_DATA  = 32;

    localparam logic [W_LINES-1:0] LINE_COUNT_MAX = '1;

    localparam logic [W_LEN-1:0]  LINE_WIDTH_RST    = 8'd80;
    localparam logic [W_MAXL-1:0] MAX_LINES_RST     = 16'd60;
    localparam logic [W_EXP-1:0]  COST_EXPONENT_RST = 3'd2;
    localparam logic [W_WT-1:0]   COST_WEIGHT_RST   = 8'd1;

    typedef enum logic [1:0] {
        REG_LINE_WIDTH,
        REG_MAX_LINES,
        REG_COST_EXPONENT,
        REG_COST_WEIGHT
    } t_reg_idx;

    typedef struct packed {
        logic [W_LEN-1:0]  line_width;
        logic [W_MAXL-1:0] max_lines;
        logic [W_EXP-1:0]  cost_exponent;
        logic [W_WT-1:0]   cost_weight;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_POW,
        S_EMIT_CLOSE,
        S_PLACE,
        S_LAST_INIT,
        S_TOTAL,
        S_EMIT_FINAL
    } t_state;

    typedef enum logic [1:0] {
        PH_CLOSE,
        PH_LAST,
        PH_LEFT
    } t_phase;

    typedef struct packed {
        logic load;
        logic pow_init_line;
        logic pow_init_left;
        logic pow_step;
        logic pow_weight;
        logic emit_close;
        logic place;
        logic total;
        logic emit_final;
    } t_dp_cmd;

    typedef struct packed {
        logic need_close;
        logic last;
        logic exp_zero;
        logic too_many;
        logic out_free;
    } t_dp_stat;

endpackage

[src/glb_regs.sv]
// Configuration registers of the greedy line breaker behind an APB-style port.
// Depends on glb_pkg for the register indexes, reset values and t_cfg.
module glb_regs
    import glb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [W_ADDR-1:0] paddr,
    input  logic [W_DATA-1:0] pwdata,
    output logic [W_DATA-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width    <= LINE_WIDTH_RST;
            r_cfg.max_lines     <= MAX_LINES_RST;
            r_cfg.cost_exponent <= COST_EXPONENT_RST;
            r_cfg.cost_weight   <= COST_WEIGHT_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_LINE_WIDTH:    r_cfg.line_width    <= pwdata[W_LEN-1:0];
                REG_MAX_LINES:     r_cfg.max_lines     <= pwdata[W_MAXL-1:0];
                REG_COST_EXPONENT: r_cfg.cost_exponent <= pwdata[W_EXP-1:0];
                REG_COST_WEIGHT:   r_cfg.cost_weight   <= pwdata[W_WT-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LINE_WIDTH:    prdata = W_DATA'(r_cfg.line_width);
            REG_MAX_LINES:     prdata = W_DATA'(r_cfg.max_lines);
            REG_COST_EXPONENT: prdata = W_DATA'(r_cfg.cost_exponent);
            REG_COST_WEIGHT:   prdata = W_DATA'(r_cfg.cost_weight);
            default:           prdata = '0;
        endcase
    end

endmodule

[src/glb_ctrl.sv]
// Controller state machine of the greedy line breaker: sequences line closing,
// the power loop, the final totals and the output writes. Depends on glb_pkg.
module glb_ctrl
    import glb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_CLOSE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.need_close) begin
                    n_state = S_POW;
                    n_phase = PH_CLOSE;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_POW: begin
                if (i_stat.exp_zero) begin
                    case (r_phase)
                        PH_CLOSE: n_state = S_EMIT_CLOSE;
                        PH_LAST:  n_state = S_TOTAL;
                        default:  n_state = S_EMIT_FINAL;
                    endcase
                end
            end
            S_EMIT_CLOSE: begin
                if (i_stat.out_free) n_state = S_PLACE;
            end
            S_PLACE: begin
                n_state = i_stat.last ? S_LAST_INIT : S_IDLE;
            end
            S_LAST_INIT: begin
                n_state = S_POW;
                n_phase = PH_LAST;
            end
            S_TOTAL: begin
                if (i_stat.too_many) begin
                    n_state = S_EMIT_FINAL;
                end else begin
                    n_state = S_POW;
                    n_phase = PH_LEFT;
                end
            end
            S_EMIT_FINAL: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHECK:      o_cmd.pow_init_line = i_stat.need_close;
            S_POW: begin
                o_cmd.pow_weight = i_stat.exp_zero;
                o_cmd.pow_step   = !i_stat.exp_zero;
            end
            S_EMIT_CLOSE: o_cmd.emit_close = i_stat.out_free;
            S_PLACE:      o_cmd.place = 1'b1;
            S_LAST_INIT:  o_cmd.pow_init_line = 1'b1;
            S_TOTAL: begin
                o_cmd.total         = 1'b1;
                o_cmd.pow_init_left = !i_stat.too_many;
            end
            S_EMIT_FINAL: o_cmd.emit_final = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

[src/glb_dp.sv]
// Datapath of the greedy line breaker: text state, the shared saturating
// multiplier of the power loop, and the output register. Depends on glb_pkg.
module glb_dp
    import glb_pkg::*;
#(
    parameter int MAX_WORDS    = 65536,
    parameter int COST_CEILING = 2147483647
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [W_LEN-1:0]   i_word_length,
    input  logic               i_last_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [W_IDX-1:0]   o_line_end_index,
    output logic [W_COST-1:0]  o_line_badness,
    output logic [W_COST-1:0]  o_text_badness,
    output logic               o_too_many_lines,
    output logic               o_final_res
);

    localparam logic [W_COST-1:0] CEIL     = W_COST'(COST_CEILING);
    localparam logic [W_IDX-1:0]  IDX_LAST = W_IDX'(MAX_WORDS - 1);
    localparam logic [W_IDX:0]    IDX_END  = (W_IDX + 1)'(MAX_WORDS);

    function automatic logic [W_COST-1:0] sat_add(input logic [W_COST-1:0] a,
                                                 input logic [W_COST-1:0] b);
        logic [W_COST:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, CEIL}) ? CEIL : s[W_COST-1:0];
    endfunction

    // Item and text state
    logic [W_LEN-1:0]   r_word_len;
    logic               r_last;
    logic [W_FILL-1:0]  r_line_fill;
    logic [W_IDX-1:0]   r_word_index;
    logic [W_LINES-1:0] r_line_count;
    logic [W_COST-1:0]  r_running;
    // Power loop
    logic [W_COST-1:0]  r_acc;
    logic [W_BASE-1:0]  r_base;
    logic [W_EXP-1:0]   r_exp_cnt;
    logic               r_ovf;
    // Final line holding registers
    logic [W_COST-1:0]  r_line_badness;
    logic [W_COST-1:0]  r_total;
    logic               r_many;
    // Output register
    logic               r_out_valid;
    logic [W_IDX-1:0]   r_out_idx;
    logic [W_COST-1:0]  r_out_cost;
    logic [W_COST-1:0]  r_out_total;
    logic               r_out_many;
    logic               r_out_final;

    logic [W_FILL-1:0]  w_line_len;
    logic               w_line_ovf;
    logic [W_FILL-1:0]  w_line_diff;
    logic [W_LINES-1:0] w_lines;
    logic               w_too_many;
    logic [W_LINES-1:0] w_left_diff;
    logic [W_FILL:0]    w_fit_sum;
    logic [W_BASE-1:0]  w_mul_b;
    logic [W_PROD-1:0]  w_prod;
    logic [W_COST-1:0]  w_prod_sat;
    logic [W_IDX-1:0]   w_prev_idx;
    logic [W_IDX:0]     w_idx_inc;
    logic               w_out_free;

    assign w_line_len  = r_line_fill - W_FILL'(1);
    assign w_line_ovf  = w_line_len > {1'b0, i_cfg.line_width};
    assign w_line_diff = {1'b0, i_cfg.line_width} - w_line_len;
    assign w_lines     = (r_line_count < LINE_COUNT_MAX) ? r_line_count + W_LINES'(1)
                                                         : r_line_count;
    assign w_too_many  = w_lines > {1'b0, i_cfg.max_lines};
    assign w_left_diff = {1'b0, i_cfg.max_lines} - w_lines;
    assign w_fit_sum   = {1'b0, r_line_fill} + (W_FILL + 1)'(r_word_len);
    assign w_mul_b     = i_cmd.pow_weight ? W_BASE'(i_cfg.cost_weight) : r_base;
    assign w_prod      = W_PROD'(r_acc) * W_PROD'(w_mul_b);
    assign w_prod_sat  = (w_prod > W_PROD'(CEIL)) ? CEIL : w_prod[W_COST-1:0];
    assign w_prev_idx  = (r_word_index == '0) ? IDX_LAST : r_word_index - W_IDX'(1);
    assign w_idx_inc   = {1'b0, r_word_index} + (W_IDX + 1)'(1);
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign o_stat.need_close = (r_line_fill != '0) &&
                               (w_fit_sum > (W_FILL + 1)'(i_cfg.line_width));
    assign o_stat.last       = r_last;
    assign o_stat.exp_zero   = (r_exp_cnt == '0);
    assign o_stat.too_many   = w_too_many;
    assign o_stat.out_free   = w_out_free;

    // Control-bearing text state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_fill  <= '0;
            r_word_index <= '0;
            r_line_count <= '0;
            r_running    <= '0;
        end else if (i_cmd.emit_close) begin
            r_running    <= sat_add(r_running, r_acc);
            r_line_count <= w_lines;
            r_line_fill  <= '0;
        end else if (i_cmd.place) begin
            if (r_line_fill == '0) begin
                r_line_fill <= W_FILL'(r_word_len) + W_FILL'(1);
            end else begin
                r_line_fill <= r_line_fill + W_FILL'(r_word_len) + W_FILL'(1);
            end
            if (!r_last) begin
                r_word_index <= (w_idx_inc >= IDX_END) ? '0 : w_idx_inc[W_IDX-1:0];
            end
        end else if (i_cmd.emit_final) begin
            r_line_fill  <= '0;
            r_word_index <= '0;
            r_line_count <= '0;
            r_running    <= '0;
        end
    end

    // Item capture, power loop and final holding registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word_len <= i_word_length;
            r_last     <= i_last_word;
        end
        if (i_cmd.pow_init_line || i_cmd.pow_init_left) begin
            r_acc     <= W_COST'(1);
            r_exp_cnt <= i_cfg.cost_exponent;
        end else if (i_cmd.pow_step) begin
            r_acc     <= w_prod_sat;
            r_exp_cnt <= r_exp_cnt - W_EXP'(1);
        end else if (i_cmd.pow_weight) begin
            r_acc <= r_ovf ? CEIL : w_prod_sat;
        end
        if (i_cmd.pow_init_line) begin
            r_base <= W_BASE'(w_line_diff[W_LEN-1:0]);
            r_ovf  <= w_line_ovf;
        end else if (i_cmd.pow_init_left) begin
            r_base <= w_left_diff[W_BASE-1:0];
            r_ovf  <= 1'b0;
        end
        if (i_cmd.total) begin
            r_line_badness <= r_acc;
            r_total        <= sat_add(r_running, r_acc);
            r_many         <= w_too_many;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_close || i_cmd.emit_final) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_close) begin
            r_out_idx   <= w_prev_idx;
            r_out_cost  <= r_acc;
            r_out_total <= '0;
            r_out_many  <= 1'b0;
            r_out_final <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_out_idx   <= r_word_index;
            r_out_cost  <= r_line_badness;
            r_out_total <= r_many ? CEIL : sat_add(r_total, r_acc);
            r_out_many  <= r_many;
            r_out_final <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_line_end_index = r_out_idx;
    assign o_line_badness   = r_out_cost;
    assign o_text_badness   = r_out_total;
    assign o_too_many_lines = r_out_many;
    assign o_final_res      = r_out_final;

endmodule

[src/greedy_line_breaker.sv]
// Top level of the greedy line breaker: configuration registers, controller and datapath.
// Depends on glb_pkg, glb_regs, glb_ctrl and glb_dp.
//
// The block takes one word length at a time and packs words greedily onto lines of
// line_width characters, one space between neighbouring words. Whenever a word does
// not fit, the open line is closed and a result word carries the index of its last
// word and its cost, cost_weight * (line_width - length)^cost_exponent, saturated at
// COST_CEILING; a word longer than the line sits alone on a line costed at the ceiling.
// The word marked last_word closes the final line as well, and its result (final_res
// set) also carries the text's total cost including the penalty for unused lines, or
// the ceiling with too_many_lines set when the text ran past max_lines. One word is
// worked on at a time: a word that does not fit first runs the power loop for the cost
// of the line it closes, and the last word runs it again for the final line and, unless
// the text ran past max_lines, for the unused lines. The power loop shares one
// 31 x 16 bit saturating multiplier and does one multiplication per cycle. A new word
// is accepted while a result still waits in the output register; the block only stalls
// when it has a further result to deliver and that register is still full.
// Configuration must be written through the APB-style port only while the block is
// idle; the block itself does not enforce it. Registers sit at byte addresses
// 0 (line_width), 4 (max_lines), 8 (cost_exponent) and 12 (cost_weight).
module greedy_line_breaker
    import glb_pkg::*;
#(
    parameter int MAX_WORDS    = 65536,
    parameter int COST_CEILING = 2147483647
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [W_ADDR-1:0] paddr,
    input  logic [W_DATA-1:0] pwdata,
    output logic [W_DATA-1:0] prdata,
    output logic              pready,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [W_LEN-1:0]  i_word_length,
    input  logic              i_last_word,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [W_IDX-1:0]  o_line_end_index,
    output logic [W_COST-1:0] o_line_badness,
    output logic [W_COST-1:0] o_text_badness,
    output logic              o_too_many_lines,
    output logic              o_final_res
);

    t_cfg     w_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    glb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The controller only sequences; all arithmetic and the text state live in the datapath.
    glb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    glb_dp #(
        .MAX_WORDS    (MAX_WORDS),
        .COST_CEILING (COST_CEILING)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_word_length    (i_word_length),
        .i_last_word      (i_last_word),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_line_end_index (o_line_end_index),
        .o_line_badness   (o_line_badness),
        .o_text_badness   (o_text_badness),
        .o_too_many_lines (o_too_many_lines),
        .o_final_res      (o_final_res)
    );

endmodule

[src/glb_checker.sv]
// Port-level checker for the greedy line breaker and its bind to the top level.
// Depends on glb_pkg for the field widths.
module glb_checker
    import glb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [W_IDX-1:0]  o_line_end_index,
    input logic [W_COST-1:0] o_line_badness,
    input logic [W_COST-1:0] o_text_badness,
    input logic              o_too_many_lines,
    input logic              o_final_res
);

    // A word that waits must hold still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_line_end_index)
            && $stable(o_line_badness) && $stable(o_text_badness)
            && $stable(o_too_many_lines) && $stable(o_final_res))
        else $error("output word changed while stalled");

    // Ready is only given in the idle state, so it must drop after an acceptance.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted on back-to-back cycles");

    a_many_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_too_many_lines |-> o_final_res)
        else $error("too_many_lines set on a non-final result");

    a_total_zero_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_final_res |-> o_text_badness == '0)
        else $error("total cost non-zero on a non-final result");

endmodule

bind greedy_line_breaker glb_checker u_glb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_line_end_index (o_line_end_index),
    .o_line_badness   (o_line_badness),
    .o_text_badness   (o_text_badness),
    .o_too_many_lines (o_too_many_lines),
    .o_final_res      (o_final_res)
);
